### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### sv/mso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mso_pkg
// Shared types and constants of the marquee scroll offset block.
// ----------------------------------------------------------------------------
package mso_pkg;

  localparam int unsigned OFFSET_W = 13;
  localparam int unsigned CYCLE_W  = 18;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned MS_W     = 10;
  localparam int unsigned SPEED_W  = 16;

  localparam logic [MS_W-1:0] MS_PER_S = 10'd1000;

  typedef logic [2:0] reg_index_t;

  localparam reg_index_t REG_MODE   = 3'd0;
  localparam reg_index_t REG_SPEED  = 3'd1;
  localparam reg_index_t REG_TMIN   = 3'd2;
  localparam reg_index_t REG_TMAX   = 3'd3;
  localparam reg_index_t REG_LHOLD  = 3'd4;
  localparam reg_index_t REG_BHOLD  = 3'd5;
  localparam reg_index_t REG_PAUSE  = 3'd6;

  typedef enum logic [1:0] {
    PH_OUT,
    PH_FULL,
    PH_BACK,
    PH_ZERO
  } phase_t;

endpackage

### sv/mso_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mso_cfg
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
module mso_cfg #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned CFG_W     = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  mso_pkg::reg_index_t     cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    mode,
  output logic [15:0]             speed,
  output logic [TIME_BITS-1:0]    tmin,
  output logic [TIME_BITS-1:0]    tmax,
  output logic [TIME_BITS-1:0]    lhold,
  output logic [TIME_BITS-1:0]    bhold,
  output logic [TIME_BITS-1:0]    pause
);
  import mso_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      speed <= 16'd30;
      tmin  <= TIME_BITS'(1000);
      tmax  <= TIME_BITS'(8000);
      lhold <= TIME_BITS'(1000);
      bhold <= TIME_BITS'(1000);
      pause <= TIME_BITS'(1500);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:  mode  <= cfg_data[0];
        REG_SPEED: speed <= cfg_data[15:0];
        REG_TMIN:  tmin  <= cfg_data[TIME_BITS-1:0];
        REG_TMAX:  tmax  <= cfg_data[TIME_BITS-1:0];
        REG_LHOLD: lhold <= cfg_data[TIME_BITS-1:0];
        REG_BHOLD: bhold <= cfg_data[TIME_BITS-1:0];
        REG_PAUSE: pause <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/mso_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mso_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module mso_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] out_side
);
  import mso_pkg::*;

  logic          v_q [NW];
  logic [NW-1:0] n_q [NW];
  logic [DW-1:0] r_q [NW];
  logic [DW-1:0] d_q [NW];
  logic [SW-1:0] s_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          vp;
    logic [NW-1:0] np;
    logic [DW-1:0] rp;
    logic [DW-1:0] dp;
    logic [SW-1:0] sp;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign vp = in_valid;
      assign np = num;
      assign rp = '0;
      assign dp = den;
      assign sp = side;
    end else begin : g_next
      assign vp = v_q[i-1];
      assign np = n_q[i-1];
      assign rp = r_q[i-1];
      assign dp = d_q[i-1];
      assign sp = s_q[i-1];
    end

    assign trial = {rp, np[NW-1]};
    assign diff  = trial - {1'b0, dp};
    assign ge    = trial >= {1'b0, dp};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[i] <= {np[NW-2:0], ge};
        r_q[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        d_q[i] <= dp;
        s_q[i] <= sp;
      end
    end
  end

  assign out_valid = v_q[NW-1];
  assign quo       = n_q[NW-1];
  assign rem       = r_q[NW-1];
  assign out_side  = s_q[NW-1];

endmodule

### sv/marquee_scroll_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marquee_scroll_offset
// Horizontal draw offset and cycle length of a marquee-scrolled text line.
// ----------------------------------------------------------------------------
// Items enter on the s_ stream (text width, view width, elapsed time) and
// results leave on the m_ stream (pixel offset, cycle length). Registers are
// written on the cfg_ channel, which is always ready; write them only while
// no item is in flight.
// The pipeline has one input stage, a PIXEL_BITS+10 stage divider for the
// traversal time, a clamp and cycle-sum stage, a 32 stage divider for the
// phase, a phase decode stage, a multiply stage, a PIXEL_BITS+TIME_BITS
// stage divider for the covered distance and an output register.
// Throughput is one item per cycle while the receiver does not stall; the
// three dividers retire one quotient bit per stage.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the whole pipeline holds and s_tready falls.
// ----------------------------------------------------------------------------
module marquee_scroll_offset #(
  parameter int unsigned PIXEL_BITS = 12,
  parameter int unsigned TIME_BITS  = 16,
  localparam int unsigned IN_W  = ((2 * PIXEL_BITS + 32 + 7) / 8) * 8,
  localparam int unsigned CFG_W = (TIME_BITS > 16) ? TIME_BITS : 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // txt_px, box_px, age_ms
  input  logic [IN_W-1:0]          s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // pixel_offset, cycle_length_ms
  output logic [mso_pkg::OUT_W-1:0] m_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  mso_pkg::reg_index_t      cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);
  import mso_pkg::*;

  localparam int unsigned PB  = PIXEL_BITS;
  localparam int unsigned TB  = TIME_BITS;
  localparam int unsigned CW  = TB + 2;
  localparam int unsigned NW1 = PB + MS_W;
  localparam int unsigned NW3 = PB + TB;
  localparam int unsigned EW  = NW1 + TB;
  localparam int unsigned S1W = 1 + PB + 32;
  localparam int unsigned S2W = 1 + PB + TB + CW;
  localparam int unsigned S3W = 1 + 2 + PB + CW;

  logic          mode;
  logic [15:0]   speed;
  logic [TB-1:0] tmin, tmax, lhold, bhold, pause;

  mso_cfg #(.TIME_BITS(TB), .CFG_W(CFG_W)) u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mode, .speed, .tmin, .tmax, .lhold, .bhold, .pause
  );

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input stage: overhang and overhang times one thousand.
  logic [PB-1:0]  in_tw, in_vw;
  logic [31:0]    in_el;
  logic           a_valid, a_zero;
  logic [PB-1:0]  a_dist;
  logic [31:0]    a_el;
  logic [NW1-1:0] a_prod;

  assign in_tw = s_tdata[PB-1:0];
  assign in_vw = s_tdata[2*PB-1:PB];
  assign in_el = s_tdata[2*PB+31:2*PB];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_zero <= in_tw <= in_vw;
      a_dist <= (in_tw > in_vw) ? in_tw - in_vw : '0;
      a_prod <= (in_tw > in_vw) ?
                NW1'(in_tw - in_vw) * NW1'(MS_PER_S) : '0;
      a_el   <= in_el;
    end
  end

  // Traversal time divider.
  logic           d1_valid;
  logic [NW1-1:0] d1_quo;
  logic [15:0]    d1_rem;
  logic [S1W-1:0] d1_side;

  mso_div #(.NW(NW1), .DW(SPEED_W), .SW(S1W)) u_div_travel (
    .clk, .rst, .en,
    .in_valid (a_valid),
    .num      (a_prod),
    .den      (speed),
    .side     ({a_zero, a_dist, a_el}),
    .out_valid(d1_valid),
    .quo      (d1_quo),
    .rem      (d1_rem),
    .out_side (d1_side)
  );

  // Clamp and cycle sum.
  logic          d1_zero;
  logic [PB-1:0] d1_dist;
  logic [31:0]   d1_el;
  logic [EW-1:0] p_ext, min_ext, max_ext;
  logic [TB-1:0] travel_c;
  logic [TB-1:0] hold_c;
  logic          b_valid, b_zero;
  logic [PB-1:0] b_dist;
  logic [31:0]   b_el;
  logic [TB-1:0] b_travel;
  logic [CW-1:0] b_cycle;

  assign {d1_zero, d1_dist, d1_el} = d1_side;
  assign min_ext = EW'(tmin);
  assign max_ext = EW'(tmax);
  assign p_ext   = (speed == '0) ? max_ext : EW'(d1_quo) | EW'(d1_rem & 16'h0);
  assign hold_c  = mode ? bhold : lhold;

  always_comb begin
    priority if (p_ext < min_ext) begin
      travel_c = tmin;
    end else if (p_ext > max_ext) begin
      travel_c = tmax;
    end else begin
      travel_c = p_ext[TB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_zero   <= d1_zero;
      b_dist   <= d1_dist;
      b_el     <= d1_el;
      b_travel <= travel_c;
      b_cycle  <= CW'(travel_c) + CW'(hold_c) + CW'(pause) +
                  (mode ? CW'(travel_c) : CW'(0));
    end
  end

  // Phase divider: elapsed time modulo the cycle.
  logic           d2_valid;
  logic [31:0]    d2_quo;
  logic [CW-1:0]  d2_rem;
  logic [S2W-1:0] d2_side;

  mso_div #(.NW(32), .DW(CW), .SW(S2W)) u_div_phase (
    .clk, .rst, .en,
    .in_valid (b_valid),
    .num      (b_el),
    .den      (b_cycle),
    .side     ({b_zero, b_dist, b_travel, b_cycle}),
    .out_valid(d2_valid),
    .quo      (d2_quo),
    .rem      (d2_rem),
    .out_side (d2_side)
  );

  // Phase decode.
  logic          d2_zero;
  logic [PB-1:0] d2_dist;
  logic [TB-1:0] d2_travel;
  logic [CW-1:0] d2_cycle;
  logic [CW-1:0] t0, t1, t2;
  phase_t        ph_c;
  logic [TB-1:0] tt_c;
  logic          c_valid, c_zero;
  phase_t        c_ph;
  logic [PB-1:0] c_dist;
  logic [TB-1:0] c_tt, c_travel;
  logic [CW-1:0] c_cycle;

  assign {d2_zero, d2_dist, d2_travel, d2_cycle} = d2_side;
  assign t0 = (d2_cycle == '0) ? '0 : d2_rem | CW'(d2_quo & 32'h0);
  assign t1 = t0 - CW'(d2_travel);
  assign t2 = t1 - CW'(mode ? bhold : lhold);

  always_comb begin
    tt_c = '0;
    priority if (t0 < CW'(d2_travel)) begin
      ph_c = PH_OUT;
      tt_c = t0[TB-1:0];
    end else if (t1 < CW'(mode ? bhold : lhold)) begin
      ph_c = PH_FULL;
    end else if (mode && (t2 < CW'(d2_travel))) begin
      ph_c = PH_BACK;
      tt_c = t2[TB-1:0];
    end else begin
      ph_c = PH_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_zero   <= d2_zero;
      c_ph     <= ph_c;
      c_dist   <= d2_dist;
      c_tt     <= tt_c;
      c_travel <= d2_travel;
      c_cycle  <= d2_cycle;
    end
  end

  // Covered-distance product.
  logic           e_valid, e_zero;
  phase_t         e_ph;
  logic [PB-1:0]  e_dist;
  logic [NW3-1:0] e_prod;
  logic [TB-1:0]  e_travel;
  logic [CW-1:0]  e_cycle;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_zero   <= c_zero;
      e_ph     <= c_ph;
      e_dist   <= c_dist;
      e_prod   <= NW3'(c_dist) * NW3'(c_tt);
      e_travel <= c_travel;
      e_cycle  <= c_cycle;
    end
  end

  // Covered-distance divider.
  logic           d3_valid;
  logic [NW3-1:0] d3_quo;
  logic [TB-1:0]  d3_rem;
  logic [S3W-1:0] d3_side;

  mso_div #(.NW(NW3), .DW(TB), .SW(S3W)) u_div_cover (
    .clk, .rst, .en,
    .in_valid (e_valid),
    .num      (e_prod),
    .den      (e_travel),
    .side     ({e_zero, e_ph, e_dist, e_cycle}),
    .out_valid(d3_valid),
    .quo      (d3_quo),
    .rem      (d3_rem),
    .out_side (d3_side)
  );

  // Output register.
  logic                    d3_zero;
  logic [1:0]              d3_ph_bits;
  phase_t                  d3_ph;
  logic [PB-1:0]           d3_dist;
  logic [CW-1:0]           d3_cycle;
  logic [PB-1:0]           q3;
  logic [PB-1:0]           back_c;
  logic [PB+OFFSET_W-1:0]  neg_c;
  logic [CW+CYCLE_W-1:0]   cyc_ext;
  logic                    out_valid;
  logic [OFFSET_W-1:0]     out_offset;
  logic [CYCLE_W-1:0]      out_cycle;

  assign {d3_zero, d3_ph_bits, d3_dist, d3_cycle} = d3_side;
  assign d3_ph = phase_t'(d3_ph_bits);
  assign q3    = d3_quo[PB-1:0] | PB'(d3_rem & '0);

  always_comb begin
    unique case (d3_ph)
      PH_OUT:  back_c = q3;
      PH_FULL: back_c = d3_dist;
      PH_BACK: back_c = d3_dist - q3;
      PH_ZERO: back_c = '0;
      default: back_c = '0;
    endcase
  end

  assign neg_c   = (PB+OFFSET_W)'(0) - (PB+OFFSET_W)'(back_c);
  assign cyc_ext = (CW+CYCLE_W)'(d3_cycle);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_offset <= d3_zero ? '0 : neg_c[OFFSET_W-1:0];
      out_cycle  <= d3_zero ? '0 : cyc_ext[CYCLE_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W - OFFSET_W - CYCLE_W){1'b0}}, out_cycle, out_offset};

endmodule

### sv/mso_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mso_checker
// Port-level checks of the marquee scroll offset block, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mso_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import mso_pkg::*;

  `CHK_NEXT(a_valid_holds, m_tvalid && !m_tready, m_tvalid)
  `CHK_NEXT(a_data_holds, m_tvalid && !m_tready, $stable(m_tdata))
  `CHK_SAME(a_ready_stall, !s_tready, m_tvalid && !m_tready)
  `CHK_SAME(a_zero_cycle, m_tvalid && (m_tdata[30:13] == '0), m_tdata[12:0] == '0)

endmodule

bind marquee_scroll_offset mso_checker u_mso_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the marquee scroll offset block. Items are
// streamed in, with random gaps and receiver stalls, and every result is
// compared with an offset and cycle length worked out here from the
// current register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import mso_pkg::*;

  localparam int unsigned IN_W = 56;
  localparam int LATENCY = 87;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [17:0] cycle_length_ms;
    logic [12:0] pixel_offset;
  } offset_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // txt_px, box_px, age_ms
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // pixel_offset, cycle_length_ms
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_index_t cfg_index = REG_MODE;
  logic [15:0] cfg_data = '0;

  logic bounce_mode;
  logic [15:0] speed, tmin, tmax, lhold, bhold, pause_ms;

  offset_result_t pending_offsets[$];
  int errors = 0;
  longint cycle_count = 0;
  int long_hold = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  marquee_scroll_offset u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL marquee_scroll_offset");
      $finish;
    end
  end

  function automatic offset_result_t scroll_offset(logic [11:0] tw, logic [11:0] vw,
                                                   logic [31:0] elapsed);
    longint unsigned span, travel, hold, cyc, t, back, p;
    offset_result_t r;
    if (tw <= vw) begin
      r.pixel_offset = '0;
      r.cycle_length_ms = '0;
      return r;
    end
    span = tw - vw;
    if (speed == 0) p = tmax;
    else p = (span * 1000) / speed;
    if (p < tmin) travel = tmin;
    else if (p > tmax) travel = tmax;
    else travel = p;
    hold = bounce_mode ? bhold : lhold;
    cyc = travel + hold + pause_ms + (bounce_mode ? travel : 0);
    t = (cyc == 0) ? 0 : elapsed % cyc;
    if (t < travel) begin
      back = (span * t) / travel;
    end else begin
      t -= travel;
      if (t < hold) back = span;
      else begin
        t -= hold;
        if (bounce_mode && t < travel) back = span - (span * t) / travel;
        else back = 0;
      end
    end
    r.pixel_offset = 13'(-back);
    r.cycle_length_ms = 18'(cyc);
    return r;
  endfunction

  // Receiver: random stall pattern, with an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= stalls_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    offset_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[30:0];
      if (pending_offsets.size() == 0) begin
        $error("unexpected transfer on result stream");
        errors++;
      end else begin
        want = pending_offsets.pop_front();
        if (got.pixel_offset !== want.pixel_offset) begin
          $error("pixel_offset expected %0d got %0d", $signed(want.pixel_offset),
                 $signed(got.pixel_offset));
          errors++;
        end
        if (got.cycle_length_ms !== want.cycle_length_ms) begin
          $error("cycle_length_ms expected %0d got %0d", want.cycle_length_ms,
                 got.cycle_length_ms);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic [11:0] tw, logic [11:0] vw, logic [31:0] elapsed);
    s_tvalid <= 1'b1;
    s_tdata <= {8'h00, elapsed, vw, tw};
    do @(posedge clk); while (!s_tready);
    pending_offsets.push_back(scroll_offset(tw, vw, elapsed));
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE:  bounce_mode = value[0];
      REG_SPEED: speed = value;
      REG_TMIN:  tmin = value;
      REG_TMAX:  tmax = value;
      REG_LHOLD: lhold = value;
      REG_BHOLD: bhold = value;
      REG_PAUSE: pause_ms = value;
      default: ;
    endcase
  endtask

  task automatic set_all(logic m, logic [15:0] sp, logic [15:0] mn, logic [15:0] mx,
                         logic [15:0] lh, logic [15:0] bh, logic [15:0] pz);
    write_reg(REG_MODE, {15'd0, m});
    write_reg(REG_SPEED, sp);
    write_reg(REG_TMIN, mn);
    write_reg(REG_TMAX, mx);
    write_reg(REG_LHOLD, lh);
    write_reg(REG_BHOLD, bh);
    write_reg(REG_PAUSE, pz);
  endtask

  task automatic random_item();
    logic [11:0] tw, vw;
    logic [31:0] el;
    tw = 12'($urandom);
    vw = 12'($urandom);
    if ($urandom_range(0, 3) == 0) vw = 12'($urandom_range(0, 40));
    if ($urandom_range(0, 5) == 0) tw = 12'hFFF;
    el = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40000) : $urandom;
    send_item(tw, vw, el);
  endtask

  task automatic test_directed();
    send_item(12'd0, 12'd0, 32'd0);
    send_item(12'd100, 12'd200, 32'd5000);
    send_item(12'hFFF, 12'd0, 32'hFFFF_FFFF);
    send_item(12'hFFF, 12'd0, 32'd0);
    send_item(12'd400, 12'd100, 32'd4000);
    send_item(12'd400, 12'd100, 32'd10500);
    send_item(12'd400, 12'd100, 32'd11900);
    send_item(12'd1, 12'd0, 32'd123456);
    send_item(12'hAAA, 12'h555, 32'hAAAA_5555);
    drain();
    set_all(1'b1, 16'd30, 16'd1000, 16'd8000, 16'd1000, 16'd1000, 16'd1500);
    send_item(12'd400, 12'd100, 32'd2000);
    send_item(12'd400, 12'd100, 32'd9500);
    send_item(12'd400, 12'd100, 32'd14000);
    send_item(12'd400, 12'd100, 32'd19500);
    send_item(12'h555, 12'hAAA, 32'h5555_AAAA);
    drain();
    // Minimum above maximum, then zero travel with a zero cycle.
    set_all(1'b0, 16'd1, 16'd5000, 16'd200, 16'd0, 16'd0, 16'd0);
    send_item(12'd50, 12'd10, 32'd150);
    drain();
    write_reg(REG_MODE, 16'd1);
    send_item(12'd50, 12'd10, 32'd350);
    drain();
    set_all(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(12'd50, 12'd10, 32'd7);
    drain();
    write_reg(REG_BHOLD, 16'd9);
    send_item(12'd50, 12'd10, 32'd3);
    drain();
  endtask

  task automatic test_settings_sweep();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_all(1'b0, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: set_all(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_all(1'b1, 16'd1, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        3: set_all(1'b0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
        default: set_all(1'($urandom_range(0, 1)), 16'($urandom),
                         16'($urandom_range(1, 3000)), 16'($urandom_range(1, 20000)),
                         16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                         16'($urandom_range(0, 3000)));
      endcase
      for (int i = 0; i < 70; i++) random_item();
      drain();
    end
  endtask

  task automatic test_backpressure();
    set_all(1'b1, 16'd30, 16'd1000, 16'd8000, 16'd1000, 16'd1000, 16'd1500);
    gaps_on = 1'b0;
    long_hold = 400;
    for (int i = 0; i < 150; i++) random_item();
    gaps_on = 1'b1;
    drain();
  endtask

  task automatic test_random_stream();
    stalls_on = 1'b0;
    gaps_on = 1'b0;
    for (int i = 0; i < 60; i++) random_item();
    stalls_on = 1'b1;
    gaps_on = 1'b1;
    for (int i = 0; i < 60; i++) random_item();
    drain();
  endtask

  initial begin
    bounce_mode = 1'b0;
    speed = 16'd30;
    tmin = 16'd1000;
    tmax = 16'd8000;
    lhold = 16'd1000;
    bhold = 16'd1000;
    pause_ms = 16'd1500;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings_sweep();
    test_backpressure();
    test_random_stream();
    if (errors == 0) begin
      $display("PASS marquee_scroll_offset");
    end else begin
      $display("FAIL marquee_scroll_offset");
    end
    $finish;
  end
endmodule
